/* sv/pls_pkg.sv */
package pls_pkg;

    localparam int CMD_W        = 3;
    localparam int VAL_W        = 32;
    localparam int POS_W        = 5;
    localparam int STATUS_W     = 3;
    localparam int LEN_W        = 5;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND    = 3'd0,
        CMD_PREPEND   = 3'd1,
        CMD_INSERT    = 3'd2,
        CMD_DISPLAY   = 3'd3,
        CMD_UPDATE    = 3'd4,
        CMD_DEL_FIRST = 3'd5,
        CMD_DEL_LAST  = 3'd6,
        CMD_DEL_AT    = 3'd7
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_BADIDX = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_FULL   = 3'd3,
        ST_ITEM   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        OP_EMIT,
        OP_UPD,
        OP_INS,
        OP_DEL,
        OP_DSP
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_CHK,
        S_INS_RD,
        S_INS_WR,
        S_DEL_CHK,
        S_DEL_RD,
        S_DEL_WR,
        S_DSP_RD,
        S_DSP_LD,
        S_DSP_WAIT,
        S_WAIT
    } t_state;

endpackage

/* sv/positional_list_store.sv */
// Channel   Direction  Handshake                  Payload
// command   in         i_in_valid / o_in_stall    i_command, i_value, i_position
// result    out        o_out_valid / i_out_stall  o_status, o_element, o_last, o_length
//
// One command is taken at a time; o_in_stall stays high until its last result is transferred.
// Insert and delete move elements one at a time through the element memory, each move
// going through a check, a read and a write state before the status result is loaded.
// Display goes through a memory read, an output load and a transfer for each element.
// Reset is synchronous and active low; it empties the list and clears the output valid.
// A stalled result holds every output field until it is transferred.
module positional_list_store #(
    parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [pls_pkg::CMD_W-1:0]     i_command,
    input  logic signed [pls_pkg::VAL_W-1:0] i_value,
    input  logic [pls_pkg::POS_W-1:0]     i_position,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pls_pkg::STATUS_W-1:0]  o_status,
    output logic signed [pls_pkg::VAL_W-1:0] o_element,
    output logic                          o_last,
    output logic [pls_pkg::LEN_W-1:0]     o_length
);
    import pls_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int AW   = $clog2(CAPACITY);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [VAL_W-1:0] r_val;
    logic [POS_W-1:0] r_pos;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_idx, n_idx;
    logic [VAL_W-1:0] r_rdata;
    logic [VAL_W-1:0] r_mem [CAPACITY];

    logic r_out_valid, n_out_valid;
    t_status r_out_status, n_out_status;
    logic [VAL_W-1:0] r_out_elem, n_out_elem;
    logic r_out_last, n_out_last;

    logic in_xfer, out_xfer;
    logic [CMPW-1:0] pos_x, cnt_x;
    logic full, empty;
    t_op dec_op;
    t_status dec_status;
    logic [CW-1:0] dec_idx;
    logic [CW-1:0] ptr_inc, ptr_dec;
    logic ins_more, del_more;

    logic mem_we, mem_re, out_load;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [VAL_W-1:0] mem_wdata;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_element   = r_out_elem;
    assign o_last      = r_out_last;
    assign o_length    = LEN_W'(r_count);

    assign pos_x    = CMPW'(r_pos);
    assign cnt_x    = CMPW'(r_count);
    assign full     = (r_count == CW'(CAPACITY));
    assign empty    = (r_count == '0);
    assign ptr_inc  = r_ptr + 1'b1;
    assign ptr_dec  = r_ptr - 1'b1;
    assign ins_more = (r_ptr > r_idx);
    assign del_more = (ptr_inc < r_count);

    always_comb begin
        dec_op     = OP_EMIT;
        dec_status = ST_OK;
        dec_idx    = '0;
        unique case (r_cmd)
            CMD_APPEND: begin
                if (full) begin
                    dec_status = ST_FULL;
                end else begin
                    dec_op  = OP_INS;
                    dec_idx = r_count;
                end
            end
            CMD_PREPEND: begin
                if (full) begin
                    dec_status = ST_FULL;
                end else begin
                    dec_op = OP_INS;
                end
            end
            CMD_INSERT: begin
                if (full) begin
                    dec_status = ST_FULL;
                end else if (pos_x == '0 || pos_x > cnt_x + 1'b1) begin
                    dec_status = ST_BADIDX;
                end else begin
                    dec_op  = OP_INS;
                    dec_idx = CW'(pos_x - 1'b1);
                end
            end
            CMD_DISPLAY: begin
                if (empty) begin
                    dec_status = ST_EMPTY;
                end else begin
                    dec_op = OP_DSP;
                end
            end
            CMD_UPDATE: begin
                if (pos_x == '0 || pos_x > cnt_x) begin
                    dec_status = ST_BADIDX;
                end else begin
                    dec_op  = OP_UPD;
                    dec_idx = CW'(pos_x - 1'b1);
                end
            end
            CMD_DEL_FIRST: begin
                if (empty) begin
                    dec_status = ST_EMPTY;
                end else begin
                    dec_op = OP_DEL;
                end
            end
            CMD_DEL_LAST: begin
                if (empty) begin
                    dec_status = ST_EMPTY;
                end else begin
                    dec_op  = OP_DEL;
                    dec_idx = r_count - 1'b1;
                end
            end
            CMD_DEL_AT: begin
                if (pos_x == CMPW'(1)) begin
                    if (empty) begin
                        dec_status = ST_EMPTY;
                    end else begin
                        dec_op = OP_DEL;
                    end
                end else if (pos_x == '0 || pos_x > cnt_x) begin
                    dec_status = ST_BADIDX;
                end else begin
                    dec_op  = OP_DEL;
                    dec_idx = CW'(pos_x - 1'b1);
                end
            end
            default: begin
                dec_op = OP_EMIT;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) n_state = S_DECODE;
            end
            S_DECODE: begin
                unique case (dec_op)
                    OP_INS:  n_state = S_INS_CHK;
                    OP_DEL:  n_state = S_DEL_CHK;
                    OP_DSP:  n_state = S_DSP_RD;
                    default: n_state = S_WAIT;
                endcase
            end
            S_INS_CHK:  n_state = ins_more ? S_INS_RD : S_WAIT;
            S_INS_RD:   n_state = S_INS_WR;
            S_INS_WR:   n_state = S_INS_CHK;
            S_DEL_CHK:  n_state = del_more ? S_DEL_RD : S_WAIT;
            S_DEL_RD:   n_state = S_DEL_WR;
            S_DEL_WR:   n_state = S_DEL_CHK;
            S_DSP_RD:   n_state = S_DSP_LD;
            S_DSP_LD:   n_state = S_DSP_WAIT;
            S_DSP_WAIT: begin
                if (out_xfer) n_state = r_out_last ? S_IDLE : S_DSP_RD;
            end
            S_WAIT: begin
                if (out_xfer) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mem_we       = 1'b0;
        mem_waddr    = r_ptr[AW-1:0];
        mem_wdata    = r_rdata;
        mem_re       = 1'b0;
        mem_raddr    = r_ptr[AW-1:0];
        n_ptr        = r_ptr;
        n_idx        = r_idx;
        n_count      = r_count;
        out_load     = 1'b0;
        n_out_status = ST_OK;
        n_out_elem   = '0;
        n_out_last   = 1'b1;
        unique case (r_state)
            S_DECODE: begin
                unique case (dec_op)
                    OP_EMIT: begin
                        out_load     = 1'b1;
                        n_out_status = dec_status;
                    end
                    OP_UPD: begin
                        mem_we    = 1'b1;
                        mem_waddr = dec_idx[AW-1:0];
                        mem_wdata = r_val;
                        out_load  = 1'b1;
                    end
                    OP_INS: begin
                        n_ptr = r_count;
                        n_idx = dec_idx;
                    end
                    OP_DEL: begin
                        n_ptr = dec_idx;
                    end
                    default: begin
                        n_ptr = '0;
                    end
                endcase
            end
            S_INS_CHK: begin
                if (!ins_more) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_idx[AW-1:0];
                    mem_wdata = r_val;
                    n_count   = r_count + 1'b1;
                    out_load  = 1'b1;
                end
            end
            S_INS_RD: begin
                mem_re    = 1'b1;
                mem_raddr = ptr_dec[AW-1:0];
            end
            S_INS_WR: begin
                mem_we = 1'b1;
                n_ptr  = ptr_dec;
            end
            S_DEL_CHK: begin
                if (!del_more) begin
                    n_count  = r_count - 1'b1;
                    out_load = 1'b1;
                end
            end
            S_DEL_RD: begin
                mem_re    = 1'b1;
                mem_raddr = ptr_inc[AW-1:0];
            end
            S_DEL_WR: begin
                mem_we = 1'b1;
                n_ptr  = ptr_inc;
            end
            S_DSP_RD: begin
                mem_re = 1'b1;
            end
            S_DSP_LD: begin
                out_load     = 1'b1;
                n_out_status = ST_ITEM;
                n_out_elem   = r_rdata;
                n_out_last   = (ptr_inc == r_count);
            end
            S_DSP_WAIT: begin
                if (out_xfer && !r_out_last) n_ptr = ptr_inc;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (out_xfer) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd <= t_cmd'(i_command);
            r_val <= i_value;
            r_pos <= i_position;
        end
        r_ptr <= n_ptr;
        r_idx <= n_idx;
        if (out_load) begin
            r_out_status <= n_out_status;
            r_out_elem   <= n_out_elem;
            r_out_last   <= n_out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= r_mem[mem_raddr];
    end

endmodule

/* sv/pls_checker.sv */
module pls_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [pls_pkg::STATUS_W-1:0]  o_status,
    input logic [pls_pkg::VAL_W-1:0]     o_element,
    input logic                          o_last
);
    import pls_pkg::*;

    // A command transfer always raises the input stall in the following cycle.
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("command transfer did not raise the input stall");

    // No result is pending while a new command can be taken.
    a_idle_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid)
        else $error("result pending while ready for a command");

    // Status results are single and carry no element.
    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_ITEM) |-> (o_last && o_element == '0))
        else $error("status result without last flag or with nonzero element");

    // The final result of a command is followed by a gap.
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last) |=> !o_out_valid)
        else $error("result shown after the final result of a command");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_element)))
        else $error("stalled result changed or dropped");

endmodule

bind positional_list_store pls_checker u_pls_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_status    (o_status),
    .o_element   (o_element),
    .o_last      (o_last)
);

/* tb/sv/positional_list_store_test.sv */
`timescale 1ns / 100ps

module positional_list_store_test;

    import pls_pkg::*;

    localparam int CAPACITY        = CAPACITY_DEF;
    localparam int MAX_IDLE        = 14;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int TAIL_CYCLES     = 64;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        t_status                 status;
        logic signed [VAL_W-1:0] element;
        logic                    last;
        logic [LEN_W-1:0]        length;
    } t_list_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [CMD_W-1:0]        i_command = '0;
    logic signed [VAL_W-1:0] i_value = '0;
    logic [POS_W-1:0]        i_position = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [STATUS_W-1:0]     o_status;
    logic signed [VAL_W-1:0] o_element;
    logic                    o_last;
    logic [LEN_W-1:0]        o_length;

    logic signed [VAL_W-1:0] held_values[$];
    t_list_result            expected_results[$];

    int send_gap_max  = MAX_IDLE;
    int stall_gap_max = MAX_IDLE;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_count    = 0;
    int stall_left    = 0;
    int idle_cycles   = 0;

    int mismatch_count  = 0;
    int commands_sent   = 0;
    int results_checked = 0;
    int display_count   = 0;
    int full_refusals   = 0;

    positional_list_store dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_command  (i_command),
        .i_value    (i_value),
        .i_position (i_position),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_status   (o_status),
        .o_element  (o_element),
        .o_last     (o_last),
        .o_length   (o_length)
    );

    always #5 i_clk = ~i_clk;

    function automatic void apply_list_command(input t_cmd cmd,
                                               input logic signed [VAL_W-1:0] val,
                                               input logic [POS_W-1:0] pos);
        t_status st;
        int n;
        int p;
        st = ST_OK;
        n = held_values.size();
        p = int'(pos);
        case (cmd)
            CMD_APPEND: begin
                if (n >= CAPACITY) st = ST_FULL;
                else held_values.push_back(val);
            end
            CMD_PREPEND: begin
                if (n >= CAPACITY) st = ST_FULL;
                else held_values.push_front(val);
            end
            CMD_INSERT: begin
                if (n >= CAPACITY) st = ST_FULL;
                else if (p < 1 || p > n + 1) st = ST_BADIDX;
                else held_values.insert(p - 1, val);
            end
            CMD_DISPLAY: begin
                display_count++;
                if (n == 0) begin
                    expected_results.push_back('{ST_EMPTY, '0, 1'b1, '0});
                end else begin
                    for (int k = 0; k < n; k++) begin
                        expected_results.push_back('{ST_ITEM, held_values[k], k == n - 1,
                                                     LEN_W'(n)});
                    end
                end
                return;
            end
            CMD_UPDATE: begin
                if (p < 1 || p > n) st = ST_BADIDX;
                else held_values[p - 1] = val;
            end
            CMD_DEL_FIRST: begin
                if (n == 0) st = ST_EMPTY;
                else void'(held_values.pop_front());
            end
            CMD_DEL_LAST: begin
                if (n == 0) st = ST_EMPTY;
                else void'(held_values.pop_back());
            end
            default: begin
                if (p == 1) begin
                    if (n == 0) st = ST_EMPTY;
                    else void'(held_values.pop_front());
                end else if (p < 2 || p > n) begin
                    st = ST_BADIDX;
                end else begin
                    held_values.delete(p - 1);
                end
            end
        endcase
        if (st == ST_FULL) full_refusals++;
        expected_results.push_back('{st, '0, 1'b1, LEN_W'(held_values.size())});
    endfunction

    function automatic void compare_field(input string name, input logic [VAL_W-1:0] want,
                                          input logic [VAL_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            mismatch_count++;
        end
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_command(input t_cmd cmd, input logic signed [VAL_W-1:0] val,
                                input logic [POS_W-1:0] pos);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_value    <= val;
        i_position <= pos;
        do @(posedge i_clk); while (o_in_stall);
        apply_list_command(cmd, val, pos);
        commands_sent++;
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic send_random_command(input bit grow);
        t_cmd cmd;
        logic [POS_W-1:0] pos;
        int n;
        int roll;
        n = held_values.size();
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            cmd = CMD_DISPLAY;
        end else if (roll < 20) begin
            cmd = CMD_UPDATE;
        end else if (roll < (grow ? 80 : 40)) begin
            case ($urandom_range(0, 2))
                0: cmd = CMD_APPEND;
                1: cmd = CMD_PREPEND;
                default: cmd = CMD_INSERT;
            endcase
        end else begin
            case ($urandom_range(0, 2))
                0: cmd = CMD_DEL_FIRST;
                1: cmd = CMD_DEL_LAST;
                default: cmd = CMD_DEL_AT;
            endcase
        end
        if ($urandom_range(0, 3) == 0) pos = POS_W'($urandom_range(0, 31));
        else pos = POS_W'($urandom_range(0, n + 1));
        send_command(cmd, pick_value(), pos);
    endtask

    task automatic test_empty_list();
        send_command(CMD_DISPLAY, '0, 0);
        send_command(CMD_DEL_FIRST, '0, 0);
        send_command(CMD_DEL_LAST, '0, 0);
        send_command(CMD_DEL_AT, '0, 1);
        send_command(CMD_DEL_AT, '0, 0);
        send_command(CMD_DEL_AT, '0, 31);
        send_command(CMD_UPDATE, 32'sd5, 1);
        send_command(CMD_INSERT, 32'sd7, 0);
        send_command(CMD_INSERT, 32'sd7, 2);
        send_command(CMD_INSERT, VAL_MIN, 1);
    endtask

    task automatic test_positional_edits();
        send_command(CMD_APPEND, VAL_MAX, 0);
        send_command(CMD_PREPEND, -32'sd1, 0);
        send_command(CMD_INSERT, '0, 4);
        send_command(CMD_INSERT, 32'sh5a5a_a5a5, 2);
        send_command(CMD_INSERT, 32'sh1234_5678, 6);
        send_command(CMD_INSERT, 32'sd9, 8);
        send_command(CMD_UPDATE, VAL_MAX, 1);
        send_command(CMD_UPDATE, VAL_MIN, 6);
        send_command(CMD_UPDATE, 32'sd3, 7);
        send_command(CMD_UPDATE, 32'sd3, 0);
        send_command(CMD_DISPLAY, '0, 0);
        send_command(CMD_DEL_AT, '0, 2);
        send_command(CMD_DEL_AT, '0, 6);
        send_command(CMD_DEL_AT, '0, 5);
        send_command(CMD_DEL_LAST, '0, 0);
        send_command(CMD_DEL_FIRST, '0, 0);
        send_command(CMD_DISPLAY, '0, 0);
    endtask

    task automatic test_full_list();
        while (held_values.size() < CAPACITY) send_command(CMD_APPEND, pick_value(), 0);
        send_command(CMD_APPEND, 32'sd1, 0);
        send_command(CMD_PREPEND, 32'sd2, 0);
        send_command(CMD_INSERT, 32'sd3, 0);
        send_command(CMD_INSERT, 32'sd4, 31);
        send_command(CMD_DISPLAY, '0, 0);
        send_command(CMD_UPDATE, VAL_MIN, 16);
        send_command(CMD_UPDATE, VAL_MAX, 17);
        send_command(CMD_DEL_AT, '0, 16);
        send_command(CMD_DEL_AT, '0, 16);
        send_command(CMD_INSERT, VAL_MAX, 16);
        send_command(CMD_DISPLAY, '0, 0);
    endtask

    task automatic test_random_traffic(input int n_items);
        int segment;
        for (int k = 0; k < n_items; k++) begin
            if (k % 50 == 0) begin
                segment = (k / 50) % 4;
                send_gap_max  = (segment == 1 || segment == 3) ? 0 : MAX_IDLE;
                stall_gap_max = (segment == 2 || segment == 3) ? 0 : MAX_IDLE;
            end
            send_random_command(((k / 40) % 2) == 0);
        end
        send_gap_max  = MAX_IDLE;
        stall_gap_max = MAX_IDLE;
    endtask

    task automatic test_receiver_hold_off();
        wait_for_results();
        send_gap_max = 0;
        hold_requests++;
        repeat (12) send_random_command(1'b1);
        send_gap_max = MAX_IDLE;
        wait_for_results();
    endtask

    always @(posedge i_clk) begin : drive_result_stall
        int wait_cycles;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (hold_served != hold_requests) begin
            if (hold_count < HOLD_OFF_CYCLES) begin
                i_out_stall <= 1'b1;
                hold_count  <= hold_count + 1;
            end else begin
                i_out_stall <= 1'b0;
                hold_count  <= 0;
                hold_served <= hold_served + 1;
            end
        end else if (i_out_stall) begin
            if (stall_left > 0) stall_left <= stall_left - 1;
            else i_out_stall <= 1'b0;
        end else if (o_out_valid) begin
            wait_cycles = $urandom_range(0, stall_gap_max);
            i_out_stall <= (wait_cycles != 0);
            stall_left  <= (wait_cycles > 1) ? wait_cycles - 1 : 0;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_list_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                $error("Result transfer with no result outstanding: status %0d, element %0d",
                       o_status, o_element);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                compare_field("status", VAL_W'(want.status), VAL_W'(o_status));
                compare_field("element", want.element, o_element);
                compare_field("last", VAL_W'(want.last), VAL_W'(o_last));
                compare_field("length", VAL_W'(want.length), VAL_W'(o_length));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles.", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list();
        test_positional_edits();
        test_full_list();
        test_random_traffic(250);
        test_receiver_hold_off();
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d commands and checked %0d results, including %0d list displays.",
                 commands_sent, results_checked, display_count);
        $display("Inserts refused on a full list: %0d; receiver held off once for %0d cycles.",
                 full_refusals, HOLD_OFF_CYCLES);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
